FILE: hdl/hpl_pkg.sv
// hpl_pkg: command codes, genotype flag positions and helpers for the
// haplotype phase ligation unit; no dependencies
`timescale 1ns / 1ps

package hpl_pkg;

  typedef enum logic [1:0] {
    CMD_COMPARE = 2'd0,
    CMD_DECIDE  = 2'd1,
    CMD_APPLY   = 2'd2,
    CMD_PROMOTE = 2'd3
  } cmd_e;

  // genotype flag bit positions
  localparam int unsigned FL_MISS1   = 0;
  localparam int unsigned FL_MISS2   = 1;
  localparam int unsigned FL_PHASED  = 2;
  localparam int unsigned FL_HAPLOID = 3;

  localparam int unsigned FLAGS_W  = 4;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TOTAL_W  = 13;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // phased diploid heterozygote with no missing allele
  function automatic logic usable(input logic al1, input logic al2,
                                  input logic [FLAGS_W-1:0] fl);
    logic ok;
    ok = !fl[FL_HAPLOID] && !fl[FL_MISS1] && !fl[FL_MISS2] && fl[FL_PHASED]
         && (al1 != al2);
    return ok;
  endfunction

  // keep a set-bit total in step with one bit write, saturating both ways
  function automatic logic [TOTAL_W-1:0] total_step(input logic [TOTAL_W-1:0] tot,
                                                    input logic old_bit,
                                                    input logic new_bit);
    logic [TOTAL_W-1:0] res;
    res = tot;
    if (!old_bit && new_bit && (tot != TOTAL_MAX)) begin
      res = tot + TOTAL_W'(1);
    end else if (old_bit && !new_bit && (tot != '0)) begin
      res = tot - TOTAL_W'(1);
    end
    return res;
  endfunction

endpackage

FILE: hdl/hpl_ram.sv
// hpl_ram: generic single-write, single-read synchronous ram
// read data registered; no dependencies
`timescale 1ns / 1ps

module hpl_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/haplotype_phase_ligation_unit.sv
// haplotype_phase_ligation_unit: per-sample phase consistency between two
// overlapping chunks; uses hpl_pkg and one hpl_ram for the per-sample record
`timescale 1ns / 1ps

// usage
//  - command channel: an item is transferred at a rising edge where start is
//    high and busy is low; cmd_i selects compare, decide, apply or promote for
//    sample_i, with the two genotypes on the a_* and b_* ports
//  - result channel: every item gives one result, shown for exactly one cycle
//    with result_valid_o high; the receiver cannot stall, so it must take it
//  - result: the strobe is registered in the execute state that follows the transfer
//  - busy stays high in the cycle in which the per-sample record comes back
//    from the ram and is rewritten, so no new item is taken until the last
//    is through; a read-modify-write of a single-port-read memory
//  - per-sample state (match count, mismatch count, lower and upper swap bit)
//    lives in one ram word; the two swap totals are flip-flops
//  - reset: after rst_ni is released a clearing pass writes zero to every
//    sample record, with busy high throughout
//  - samples at or above MAX_SAMPLES touch no state; the alleles are echoed
//  - counters saturate at all ones, totals saturate at 8191 and at zero
module haplotype_phase_ligation_unit #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  hpl_pkg::cmd_e               cmd_i,
  input  logic [hpl_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                        half_i,
  input  logic                        a_allele_first_i,
  input  logic                        a_allele_second_i,
  input  logic [hpl_pkg::FLAGS_W-1:0] a_flags_i,
  input  logic                        b_allele_first_i,
  input  logic                        b_allele_second_i,
  input  logic [hpl_pkg::FLAGS_W-1:0] b_flags_i,
  output logic                        result_valid_o,
  output logic                        out_allele_first_o,
  output logic                        out_allele_second_o,
  output logic                        was_swapped_o,
  output logic                        swap_decision_o,
  output logic [hpl_pkg::TOTAL_W-1:0] swap_total_o
);

  import hpl_pkg::*;

  localparam int unsigned AW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW     = COUNT_WIDTH;
  // record layout: {upper bit, lower bit, mismatch count, match count}
  localparam int unsigned REC_W  = 2 * CW + 2;
  localparam int unsigned EXT_W  = 17;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SAMPLES - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic [AW-1:0] clr_q;

  // item captured at the transfer
  cmd_e                cmd_q;
  logic [AW-1:0]       addr_q;
  logic                ok_q;
  logic                half_q;
  logic                a1_q, a2_q, b1_q, b2_q;
  logic [FLAGS_W-1:0]  af_q, bf_q;

  logic [TOTAL_W-1:0]  upper_total_q, upper_total_d;
  logic [TOTAL_W-1:0]  lower_total_q, lower_total_d;

  logic                accept;
  logic [EXT_W-1:0]    sample_ext;
  logic                in_range;
  logic [AW-1:0]       rd_addr;

  logic [REC_W-1:0]    rd_word;
  logic [REC_W-1:0]    wr_word;
  logic [REC_W-1:0]    ram_wdata;
  logic [AW-1:0]       ram_waddr;
  logic                ram_we;

  logic [CW-1:0]       match_cur, mism_cur, match_nxt, mism_nxt;
  logic                lower_cur, upper_cur, lower_nxt, upper_nxt;

  logic                o1_d, o2_d, swapped_d, dec_d, sel_bit;

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign sample_ext = EXT_W'(sample_i);
  assign in_range   = (sample_ext < EXT_W'(MAX_SAMPLES));
  assign rd_addr    = sample_ext[AW-1:0];

  // record fields as read back from the ram in the execute state
  assign match_cur = rd_word[CW-1:0];
  assign mism_cur  = rd_word[2*CW-1:CW];
  assign lower_cur = rd_word[2*CW];
  assign upper_cur = rd_word[2*CW+1];

  // modify step of the read-modify-write
  always_comb begin
    match_nxt     = match_cur;
    mism_nxt      = mism_cur;
    lower_nxt     = lower_cur;
    upper_nxt     = upper_cur;
    upper_total_d = upper_total_q;
    lower_total_d = lower_total_q;
    o1_d          = a1_q;
    o2_d          = a2_q;
    swapped_d     = 1'b0;
    sel_bit       = half_q ? upper_cur : lower_cur;
    if (ok_q) begin
      unique case (cmd_q)
        CMD_COMPARE: begin
          if (usable(a1_q, a2_q, af_q) && usable(b1_q, b2_q, bf_q)) begin
            // lower swap bit inverts the sense of agreement
            if ((a1_q == b1_q) != lower_cur) begin
              if (match_cur != '1) begin
                match_nxt = match_cur + CW'(1);
              end
            end else begin
              if (mism_cur != '1) begin
                mism_nxt = mism_cur + CW'(1);
              end
            end
          end
        end
        CMD_DECIDE: begin
          upper_nxt     = (match_cur < mism_cur);
          upper_total_d = total_step(upper_total_q, upper_cur, upper_nxt);
          match_nxt     = '0;
          mism_nxt      = '0;
        end
        CMD_APPLY: begin
          if (sel_bit && !af_q[FL_MISS1] && !af_q[FL_HAPLOID] && af_q[FL_PHASED]) begin
            o1_d      = af_q[FL_MISS2] ? 1'b0 : a2_q;
            o2_d      = a1_q;
            swapped_d = 1'b1;
          end
        end
        CMD_PROMOTE: begin
          lower_nxt     = upper_cur;
          lower_total_d = total_step(lower_total_q, lower_cur, upper_cur);
        end
        default: begin
        end
      endcase
    end
    dec_d = ok_q && upper_nxt;
  end

  assign wr_word = {upper_nxt, lower_nxt, mism_nxt, match_nxt};

  // write port: clearing pass after reset, else the write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = wr_word;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_EXEC: begin
        ram_we = ok_q;
      end
      default: begin
      end
    endcase
  end

  hpl_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_word)
  );

  // item capture, payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      addr_q <= rd_addr;
      ok_q   <= in_range;
      half_q <= half_i;
      a1_q   <= a_allele_first_i;
      a2_q   <= a_allele_second_i;
      af_q   <= a_flags_i;
      b1_q   <= b_allele_first_i;
      b2_q   <= b_allele_second_i;
      bf_q   <= b_flags_i;
    end
  end

  // sequencer, totals and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= ST_CLEAR;
      clr_q               <= '0;
      upper_total_q       <= '0;
      lower_total_q       <= '0;
      result_valid_o      <= 1'b0;
      out_allele_first_o  <= 1'b0;
      out_allele_second_o <= 1'b0;
      was_swapped_o       <= 1'b0;
      swap_decision_o     <= 1'b0;
      swap_total_o        <= '0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == LAST_ADDR) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q             <= ST_IDLE;
          upper_total_q       <= upper_total_d;
          lower_total_q       <= lower_total_d;
          result_valid_o      <= 1'b1;
          out_allele_first_o  <= o1_d;
          out_allele_second_o <= o2_d;
          was_swapped_o       <= swapped_d;
          swap_decision_o     <= dec_d;
          swap_total_o        <= upper_total_d;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // every result comes from exactly one execute cycle
  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_EXEC))
    else $error("result strobe without execute cycle");

  // a transfer always leads to the execute cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("transfer not followed by execute");

  // the record ram is never written while idle
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("ram write while idle");

  // totals stay zero through the clearing pass
  a_clear_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (upper_total_q == '0) && (lower_total_q == '0))
    else $error("swap total changed during clearing pass");

  // apply is the only command that swaps
  a_swap_only_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && (cmd_q != CMD_APPLY) |=> !was_swapped_o)
    else $error("swap flagged for a non-apply command");

endmodule

FILE: tb/hpl_ligation_checker.sv
// hpl_ligation_checker: watches the command and result channels of the phase
// ligation unit, predicts every result and compares; depends on hpl_pkg
`timescale 1ns / 1ps

module hpl_ligation_checker #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  hpl_pkg::cmd_e                cmd_i,
  input  logic [hpl_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         half_i,
  input  logic                         a_allele_first_i,
  input  logic                         a_allele_second_i,
  input  logic [hpl_pkg::FLAGS_W-1:0]  a_flags_i,
  input  logic                         b_allele_first_i,
  input  logic                         b_allele_second_i,
  input  logic [hpl_pkg::FLAGS_W-1:0]  b_flags_i,
  input  logic                         result_valid_i,
  input  logic                         out_allele_first_i,
  input  logic                         out_allele_second_i,
  input  logic                         was_swapped_i,
  input  logic                         swap_decision_i,
  input  logic [hpl_pkg::TOTAL_W-1:0]  swap_total_i,
  output int                           errors_o,
  output int                           pending_o
);

  import hpl_pkg::*;

  typedef struct packed {
    logic               allele_first;
    logic               allele_second;
    logic               swapped;
    logic               decision;
    logic [TOTAL_W-1:0] total;
  } ligation_result_t;

  // shadow copy of the per-sample record and the two totals
  logic [COUNT_WIDTH-1:0] match_cnt    [MAX_SAMPLES];
  logic [COUNT_WIDTH-1:0] mismatch_cnt [MAX_SAMPLES];
  logic                   lower_bit    [MAX_SAMPLES];
  logic                   upper_bit    [MAX_SAMPLES];
  logic [TOTAL_W-1:0]     lower_tot;
  logic [TOTAL_W-1:0]     upper_tot;

  ligation_result_t due_results [$];
  ligation_result_t got;
  ligation_result_t want;

  function automatic logic genotype_ready(input logic al1, input logic al2,
                                          input logic [FLAGS_W-1:0] fl);
    if (fl[FL_HAPLOID] || fl[FL_MISS1] || fl[FL_MISS2]) return 1'b0;
    if (!fl[FL_PHASED]) return 1'b0;
    return al1 ^ al2;
  endfunction

  // set-bit total after one bit write, held at both ends
  function automatic logic [TOTAL_W-1:0] retally(input logic [TOTAL_W-1:0] tot,
                                                 input logic was, input logic now);
    case ({was, now})
      2'b01:   return (tot == {TOTAL_W{1'b1}}) ? tot : tot + TOTAL_W'(1);
      2'b10:   return (tot == '0) ? tot : tot - TOTAL_W'(1);
      default: return tot;
    endcase
  endfunction

  task automatic predict_ligation_item(input cmd_e c, input logic [SAMPLE_W-1:0] s,
                                       input logic h, input logic a1, input logic a2,
                                       input logic [FLAGS_W-1:0] af, input logic b1,
                                       input logic b2, input logic [FLAGS_W-1:0] bf,
                                       output ligation_result_t r);
    logic sel;
    logic v;
    r = '{allele_first: a1, allele_second: a2, swapped: 1'b0, decision: 1'b0,
          total: '0};
    if (int'(s) < MAX_SAMPLES) begin
      case (c)
        CMD_COMPARE: begin
          if (genotype_ready(a1, a2, af) && genotype_ready(b1, b2, bf)) begin
            // a set lower swap bit flips the sense of agreement
            if ((a1 == b1) ^ lower_bit[s]) begin
              if (match_cnt[s] != '1) match_cnt[s] = match_cnt[s] + COUNT_WIDTH'(1);
            end else begin
              if (mismatch_cnt[s] != '1) begin
                mismatch_cnt[s] = mismatch_cnt[s] + COUNT_WIDTH'(1);
              end
            end
          end
        end
        CMD_DECIDE: begin
          v = match_cnt[s] < mismatch_cnt[s];
          upper_tot = retally(upper_tot, upper_bit[s], v);
          upper_bit[s] = v;
          match_cnt[s] = '0;
          mismatch_cnt[s] = '0;
        end
        CMD_APPLY: begin
          sel = h ? upper_bit[s] : lower_bit[s];
          if (sel && !af[FL_MISS1] && !af[FL_HAPLOID] && af[FL_PHASED]) begin
            r.allele_first  = af[FL_MISS2] ? 1'b0 : a2;
            r.allele_second = a1;
            r.swapped       = 1'b1;
          end
        end
        default: begin
          lower_tot = retally(lower_tot, lower_bit[s], upper_bit[s]);
          lower_bit[s] = upper_bit[s];
        end
      endcase
      r.decision = upper_bit[s];
    end
    r.total = upper_tot;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_SAMPLES; k++) begin
        match_cnt[k] = '0;
        mismatch_cnt[k] = '0;
        lower_bit[k] = 1'b0;
        upper_bit[k] = 1'b0;
      end
      lower_tot = '0;
      upper_tot = '0;
      due_results.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (result_valid_i) begin
        got = {out_allele_first_i, out_allele_second_i, was_swapped_i, swap_decision_i,
               swap_total_i};
        if (due_results.size() == 0) begin
          if (errors_o < 10) $display("%0t: result with no item waiting: %p", $realtime, got);
          errors_o++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            if (errors_o < 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  first   exp %b got %b", want.allele_first, got.allele_first);
              $display("  second  exp %b got %b", want.allele_second, got.allele_second);
              $display("  swapped exp %b got %b", want.swapped, got.swapped);
              $display("  dec     exp %b got %b", want.decision, got.decision);
              $display("  total   exp %0d got %0d", want.total, got.total);
            end
            errors_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_ligation_item(cmd_i, sample_i, half_i, a_allele_first_i, a_allele_second_i,
                              a_flags_i, b_allele_first_i, b_allele_second_i, b_flags_i,
                              want);
        due_results.insert(due_results.size(), want);
      end
      pending_o = due_results.size();
    end
  end

endmodule

FILE: tb/tb.sv
// tb: stimulus and verdict for haplotype_phase_ligation_unit; the checker
// hpl_ligation_checker predicts and compares; depends on hpl_pkg
`timescale 1ns / 1ps

module tb;

  import hpl_pkg::*;

  // flag patterns used by the stimulus
  localparam logic [FLAGS_W-1:0] FLAGS_PHASED  = FLAGS_W'(1 << FL_PHASED);
  localparam logic [FLAGS_W-1:0] FLAGS_MISS2   = FLAGS_W'(1 << FL_MISS2);
  localparam logic [FLAGS_W-1:0] FLAGS_MISS1   = FLAGS_W'(1 << FL_MISS1);
  localparam logic [FLAGS_W-1:0] FLAGS_HAPLOID = FLAGS_W'(1 << FL_HAPLOID);

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  cmd_e                cmd;
  logic [SAMPLE_W-1:0] sample;
  logic                half;
  logic                a_first;
  logic                a_second;
  logic [FLAGS_W-1:0]  a_flags;
  logic                b_first;
  logic                b_second;
  logic [FLAGS_W-1:0]  b_flags;
  logic                result_valid;
  logic                out_first;
  logic                out_second;
  logic                was_swapped;
  logic                swap_decision;
  logic [TOTAL_W-1:0]  swap_total;
  int                  fail_count;
  int                  pending_cnt;

  // chance in percent that the sender holds start low before an item, drawn again after each idle
  int                  idle_pct;
  int                  items_sent;

  haplotype_phase_ligation_unit i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .cmd_i               (cmd),
    .sample_i            (sample),
    .half_i              (half),
    .a_allele_first_i    (a_first),
    .a_allele_second_i   (a_second),
    .a_flags_i           (a_flags),
    .b_allele_first_i    (b_first),
    .b_allele_second_i   (b_second),
    .b_flags_i           (b_flags),
    .result_valid_o      (result_valid),
    .out_allele_first_o  (out_first),
    .out_allele_second_o (out_second),
    .was_swapped_o       (was_swapped),
    .swap_decision_o     (swap_decision),
    .swap_total_o        (swap_total)
  );

  hpl_ligation_checker i_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start),
    .busy_i              (busy),
    .cmd_i               (cmd),
    .sample_i            (sample),
    .half_i              (half),
    .a_allele_first_i    (a_first),
    .a_allele_second_i   (a_second),
    .a_flags_i           (a_flags),
    .b_allele_first_i    (b_first),
    .b_allele_second_i   (b_second),
    .b_flags_i           (b_flags),
    .result_valid_i      (result_valid),
    .out_allele_first_i  (out_first),
    .out_allele_second_i (out_second),
    .was_swapped_i       (was_swapped),
    .swap_decision_i     (swap_decision),
    .swap_total_i        (swap_total),
    .errors_o            (fail_count),
    .pending_o           (pending_cnt)
  );

  always #5 clk_i = ~clk_i;

  // one command transfer; called at a rising edge, returns at the transfer edge
  // busy is looked at on the falling edge, where it is settled for the next edge
  task automatic push_item(input cmd_e c, input logic [SAMPLE_W-1:0] s, input logic h,
                           input logic a1, input logic a2, input logic [FLAGS_W-1:0] af,
                           input logic b1, input logic b2, input logic [FLAGS_W-1:0] bf);
    bit stalled;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start    <= 1'b1;
    cmd      <= c;
    sample   <= s;
    half     <= h;
    a_first  <= a1;
    a_second <= a2;
    a_flags  <= af;
    b_first  <= b1;
    b_second <= b2;
    b_flags  <= bf;
    do begin
      @(negedge clk_i);
      stalled = busy;
      @(posedge clk_i);
    end while (stalled);
    items_sent++;
  endtask

  // sender holds off until every predicted result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    @(posedge clk_i);
  endtask

  // one well-formed ligation pass over a sample: compares, decide, maybe
  // promote, then a few applies; a share of the compares are spoiled
  task automatic run_session();
    logic [SAMPLE_W-1:0] s;
    logic                a1, b1;
    logic [FLAGS_W-1:0]  af;
    int                  n;
    if ($urandom_range(99) < 85) begin
      // small pool at both ends of the index range so counts build up
      s = $urandom_range(1) ? SAMPLE_W'($urandom_range(7))
                            : SAMPLE_W'(4088 + $urandom_range(7));
    end else begin
      s = SAMPLE_W'($urandom_range(4095));
    end
    n = $urandom_range(1, 8);
    repeat (n) begin
      a1 = 1'($urandom_range(1));
      b1 = 1'($urandom_range(1));
      if ($urandom_range(99) < 15) begin
        push_item(CMD_COMPARE, s, 1'($urandom_range(1)), a1, 1'($urandom_range(1)),
                  FLAGS_W'($urandom_range(15)), b1, 1'($urandom_range(1)),
                  FLAGS_W'($urandom_range(15)));
      end else begin
        push_item(CMD_COMPARE, s, 1'($urandom_range(1)), a1, !a1, FLAGS_PHASED,
                  b1, !b1, FLAGS_PHASED);
      end
    end
    push_item(CMD_DECIDE, s, 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)), FLAGS_W'($urandom_range(15)), 1'($urandom_range(1)),
              1'($urandom_range(1)), FLAGS_W'($urandom_range(15)));
    if ($urandom_range(1)) begin
      push_item(CMD_PROMOTE, s, 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)), FLAGS_W'($urandom_range(15)), 1'($urandom_range(1)),
                1'($urandom_range(1)), FLAGS_W'($urandom_range(15)));
    end
    n = $urandom_range(1, 3);
    repeat (n) begin
      if ($urandom_range(99) < 60) begin
        af = FLAGS_PHASED | ($urandom_range(1) ? FLAGS_MISS2 : '0);
      end else begin
        af = FLAGS_W'($urandom_range(15));
      end
      push_item(CMD_APPLY, s, 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)), af, 1'($urandom_range(1)), 1'($urandom_range(1)),
                FLAGS_W'($urandom_range(15)));
    end
  endtask

  initial begin
    int goal;
    start      <= 1'b0;
    cmd        <= CMD_COMPARE;
    sample     <= '0;
    half       <= 1'b0;
    a_first    <= 1'b0;
    a_second   <= 1'b0;
    a_flags    <= '0;
    b_first    <= 1'b0;
    b_second   <= 1'b0;
    b_flags    <= '0;
    rst_ni     <= 1'b0;
    idle_pct   = 0;
    items_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // busy covers the clearing pass, so the first transfer simply waits

    // directed: agreement counting on sample 0
    push_item(CMD_COMPARE, 0, 0, 0, 1, FLAGS_PHASED, 0, 1, FLAGS_PHASED);
    push_item(CMD_COMPARE, 0, 0, 0, 1, FLAGS_PHASED, 1, 0, FLAGS_PHASED);
    push_item(CMD_COMPARE, 0, 0, 1, 0, FLAGS_PHASED, 0, 1, FLAGS_PHASED);
    // pairs that must not count: homozygote, missing allele, haploid
    push_item(CMD_COMPARE, 0, 0, 0, 0, FLAGS_PHASED, 0, 1, FLAGS_PHASED);
    push_item(CMD_COMPARE, 0, 0, 0, 1, FLAGS_PHASED, 0, 1, FLAGS_PHASED | FLAGS_MISS1);
    push_item(CMD_COMPARE, 0, 0, 0, 1, FLAGS_PHASED | FLAGS_HAPLOID, 1, 0, FLAGS_PHASED);
    // more mismatches than matches sets the upper swap bit
    push_item(CMD_DECIDE, 0, 0, 0, 0, '0, 0, 0, '0);
    // apply on the upper half: plain swap, second missing, then the skips
    push_item(CMD_APPLY, 0, 1, 0, 1, FLAGS_PHASED, 0, 0, '0);
    push_item(CMD_APPLY, 0, 1, 1, 0, FLAGS_PHASED | FLAGS_MISS2, 0, 0, '0);
    push_item(CMD_APPLY, 0, 1, 0, 1, FLAGS_PHASED | FLAGS_MISS1, 0, 0, '0);
    push_item(CMD_APPLY, 0, 1, 0, 1, FLAGS_PHASED | FLAGS_HAPLOID, 0, 0, '0);
    push_item(CMD_APPLY, 0, 1, 0, 1, '0, 0, 0, '0);
    // lower bit still clear, so no swap
    push_item(CMD_APPLY, 0, 0, 0, 1, FLAGS_PHASED, 0, 0, '0);
    push_item(CMD_PROMOTE, 0, 0, 0, 0, '0, 0, 0, '0);
    push_item(CMD_APPLY, 0, 0, 1, 0, FLAGS_PHASED, 0, 0, '0);
    // lower bit now set: agreement is counted inverted
    push_item(CMD_COMPARE, 0, 0, 0, 1, FLAGS_PHASED, 0, 1, FLAGS_PHASED);
    push_item(CMD_COMPARE, 0, 0, 0, 1, FLAGS_PHASED, 1, 0, FLAGS_PHASED);
    push_item(CMD_COMPARE, 0, 0, 1, 0, FLAGS_PHASED, 0, 1, FLAGS_PHASED);
    // clears the upper bit again, total steps back down
    push_item(CMD_DECIDE, 0, 0, 0, 0, '0, 0, 0, '0);
    push_item(CMD_PROMOTE, 0, 0, 0, 0, '0, 0, 0, '0);
    // top sample index, empty counters, then all ones and all zeros
    push_item(CMD_DECIDE, 4095, 0, 0, 0, '0, 0, 0, '0);
    push_item(CMD_PROMOTE, 4095, 1, 1, 1, '1, 1, 1, '1);
    push_item(CMD_COMPARE, 0, 0, 0, 0, '0, 0, 0, '0);
    wait_drained();

    // random part in three idling phases, drained between phases
    goal = items_sent + 900;
    idle_pct = 36;
    while (items_sent < goal) begin
      if ((idle_pct == 36) && (items_sent > goal - 600)) begin
        wait_drained();
        idle_pct = 79;
      end else if ((idle_pct == 79) && (items_sent > goal - 300)) begin
        wait_drained();
        idle_pct = 0;
      end
      if ($urandom_range(99) < 80) begin
        run_session();
      end else begin
        // noise: any command with any field content
        push_item(cmd_e'($urandom_range(3)), SAMPLE_W'($urandom_range(4095)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  FLAGS_W'($urandom_range(15)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), FLAGS_W'($urandom_range(15)));
      end
    end

    wait_drained();
    // let the clock run on to catch a stray strobe
    repeat (8) @(posedge clk_i);
    if ((fail_count == 0) && (pending_cnt == 0)) begin
      $display("PASS haplotype_phase_ligation_unit");
    end else begin
      $display("FAIL haplotype_phase_ligation_unit");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("FAIL haplotype_phase_ligation_unit");
    $finish;
  end

endmodule

FILE: sim.f
hdl/hpl_pkg.sv
hdl/hpl_ram.sv
hdl/haplotype_phase_ligation_unit.sv
tb/hpl_ligation_checker.sv
tb/tb.sv
